FILE: rtl/rbuv_pkg.sv
`default_nettype none
package rbuv_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int MARGIN_W = 11;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 11'd3;

  // Six division lanes: three diagonal terms, then the three off-diagonal pairs.
  localparam int NUM_LANES = 6;
  localparam int L_D0  = 0;
  localparam int L_D1  = 1;
  localparam int L_D2  = 2;
  localparam int L_O01 = 3;
  localparam int L_O02 = 4;
  localparam int L_O12 = 5;

  // Operand pair of each product lane (squares first, then cross products).
  localparam int PAIR_A [NUM_LANES] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [NUM_LANES] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
  } rbuv_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               antiparallel;
  } rbuv_out_t;

endpackage
`default_nettype wire

FILE: rtl/rbuv_divstep.sv
`default_nettype none
module rbuv_divstep import rbuv_pkg::*; #(
  parameter int CW    = 65,
  parameter int QW    = 20,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] d_i,
  input  logic [CW-1:0] rem_i [NUM_LANES],
  input  logic [QW-1:0] q_i   [NUM_LANES],
  output logic [CW-1:0] d_r,
  output logic [CW-1:0] rem_r [NUM_LANES],
  output logic [QW-1:0] q_r   [NUM_LANES]
);

  logic [CW-1:0] dsh;
  logic [CW-1:0] rem_nxt [NUM_LANES];
  logic [QW-1:0] q_nxt   [NUM_LANES];

  assign dsh = d_i << SHIFT;

  // One restoring step: this stage decides quotient bit SHIFT of every lane.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (rem_i[l] >= dsh) begin
        rem_nxt[l] = rem_i[l] - dsh;
        q_nxt[l]   = q_i[l] | (QW'(1) << SHIFT);
      end else begin
        rem_nxt[l] = rem_i[l];
        q_nxt[l]   = q_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_i;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_r[l] <= rem_nxt[l];
        q_r[l]   <= q_nxt[l];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rotation_between_unit_vectors.sv
// Rotation between two unit vectors, R = I + [v]x + [v]x^2 / (1 + c).
//
// Input channel in_valid/in_ready/in_data carries one vector pair per beat;
// the result channel out_valid/out_ready/out_data carries one 3x3 matrix and
// the antiparallel flag per beat. cfg_wr_en/cfg_wr_data write the
// antiparallel margin at once; write it only while the block is empty.
//
// Throughput is one beat per cycle while the skid register is empty. The
// restoring divider resolves one quotient bit per stage for six lanes sharing
// the divisor 1 + c, QB = max(F, 31 - F) + 3 quotient bits in all; eight
// stages of multiply and rounding and one overflow check come before it and
// one stage of sum and clamp after.
//
// Synchronous reset clears all valid bits and loads the margin with 3.
// When the receiver stalls, one result parks in a skid register and the
// pipeline keeps accepting until that register fills; then the whole
// pipeline holds and in_ready drops until the skid beat is taken.
`default_nettype none
module rotation_between_unit_vectors import rbuv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbuv_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rbuv_out_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [MARGIN_W-1:0] cfg_wr_data
);

  localparam int F   = FRAC_BITS;
  localparam int DW  = (2 * F + 2 > 35) ? 2 * F + 2 : 35;
  localparam int LW  = 34 - F;
  localparam int QB  = ((F > 31 - F) ? F : 31 - F) + 3;
  localparam int SW  = QB + 2;
  localparam int NW  = 64;
  localparam int CW  = ((NW > DW + QB + 1) ? NW : DW + QB + 1) + 1;
  localparam int NST = QB + 10;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< F;
  localparam logic [15:0] NEG_ONE16 = 16'((~(64'd1 << F)) + 64'd1);

  typedef struct packed {
    logic                 fb;
    logic signed [DW-1:0] d;
    logic signed [LW-1:0] lin0;
    logic signed [LW-1:0] lin1;
    logic signed [LW-1:0] lin2;
  } ctx_t;

  typedef struct packed {
    logic                 fb;
    logic [NUM_LANES-1:0] neg;
    logic [NUM_LANES-1:0] sat;
    logic signed [LW-1:0] lin0;
    logic signed [LW-1:0] lin1;
    logic signed [LW-1:0] lin2;
  } side_t;

  logic [MARGIN_W-1:0] margin_r;
  logic [NST-1:0]      v_r;
  logic                pipe_en;
  logic                skid_v_r;
  rbuv_out_t           skid_r;
  rbuv_out_t           res_r;
  rbuv_out_t           res_nxt;

  // Stage 1: raw products.
  logic signed [31:0] p12_r, p21_r, p20_r, p02_r, p01_r, p10_r, p00_r, p11_r, p22_r;
  // Stage 2: cross and dot product.
  logic signed [32:0] vr0_r, vr1_r, vr2_r;
  logic signed [DW-1:0] d2_r;
  // Stage 3 onward.
  logic signed [31:0] w_r [3];
  logic signed [31:0] w_nxt [3];
  ctx_t               ctx_r [3:8];
  ctx_t               ctx3_nxt;
  logic signed [47:0] pph_r [NUM_LANES];
  logic signed [48:0] ppl_r [NUM_LANES];
  logic signed [63:0] prod_r [NUM_LANES];
  logic signed [63:0] num_r [NUM_LANES];
  logic signed [63:0] nr_r [NUM_LANES];
  logic [CW-1:0]      m2_r [NUM_LANES];
  logic [NUM_LANES-1:0] neg8_r;
  logic signed [63:0] dh;
  logic signed [33:0] vr_ext [3];

  // Divider pipeline.
  logic [CW-1:0] dd_r  [QB+1];
  logic [CW-1:0] rem_r [QB+1][NUM_LANES];
  logic [QB-1:0] q_r   [QB+1][NUM_LANES];
  side_t         side_r [QB+1];
  logic [CW-1:0] dsh_ovf;
  logic [NUM_LANES-1:0] sat_nxt;

  assign pipe_en   = !skid_v_r;
  assign in_ready  = pipe_en;
  assign out_valid = skid_v_r || v_r[NST-1];
  assign out_data  = skid_v_r ? skid_r : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
    end else if (cfg_wr_en) begin
      margin_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      skid_v_r <= 1'b0;
    end else begin
      if (pipe_en) begin
        v_r <= {v_r[NST-2:0], in_valid};
      end
      // The skid register catches the result beat that the pipeline pushes out
      // while the receiver stalls.
      if (skid_v_r) begin
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (v_r[NST-1] && !out_ready) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && v_r[NST-1] && !out_ready) begin
      skid_r <= res_r;
    end
  end

  // Stages 1 and 2.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p12_r <= in_data.from_y * in_data.to_z;
      p21_r <= in_data.from_z * in_data.to_y;
      p20_r <= in_data.from_z * in_data.to_x;
      p02_r <= in_data.from_x * in_data.to_z;
      p01_r <= in_data.from_x * in_data.to_y;
      p10_r <= in_data.from_y * in_data.to_x;
      p00_r <= in_data.from_x * in_data.to_x;
      p11_r <= in_data.from_y * in_data.to_y;
      p22_r <= in_data.from_z * in_data.to_z;
      vr0_r <= 33'(p12_r) - 33'(p21_r);
      vr1_r <= 33'(p20_r) - 33'(p02_r);
      vr2_r <= 33'(p01_r) - 33'(p10_r);
      d2_r  <= DW'(p00_r) + DW'(p11_r) + DW'(p22_r) + (DW'(1) <<< (2 * F));
    end
  end

  // Stage 3: halved cross product for the quadratic term, linear term, fallback.
  always_comb begin
    vr_ext[0] = 34'(vr0_r);
    vr_ext[1] = 34'(vr1_r);
    vr_ext[2] = 34'(vr2_r);
    for (int i = 0; i < 3; i++) begin
      w_nxt[i] = 32'((vr_ext[i] + 34'sd1) >>> 1);
    end
    ctx3_nxt.fb   = (d2_r <= $signed(DW'(margin_r)));
    ctx3_nxt.d    = d2_r;
    ctx3_nxt.lin0 = LW'((vr_ext[0] + (34'sd1 <<< (F - 1))) >>> F);
    ctx3_nxt.lin1 = LW'((vr_ext[1] + (34'sd1 <<< (F - 1))) >>> F);
    ctx3_nxt.lin2 = LW'((vr_ext[2] + (34'sd1 <<< (F - 1))) >>> F);
  end

  assign dh = 64'(ctx_r[7].d >>> 1);

  // Stages 3 to 8.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      w_r      <= w_nxt;
      ctx_r[3] <= ctx3_nxt;
      for (int s = 4; s <= 8; s++) begin
        ctx_r[s] <= ctx_r[s-1];
      end
      for (int l = 0; l < NUM_LANES; l++) begin
        // Each 32x32 product is split at bit 16 into two partial products.
        pph_r[l]  <= w_r[PAIR_A[l]] * $signed(w_r[PAIR_B[l]][31:16]);
        ppl_r[l]  <= w_r[PAIR_A[l]] * $signed({1'b0, w_r[PAIR_B[l]][15:0]});
        prod_r[l] <= (64'(pph_r[l]) <<< 16) + 64'(ppl_r[l]);
        if (l < 3) begin
          num_r[l] <= -(prod_r[(l + 1) % 3] + prod_r[(l + 2) % 3]);
        end else begin
          num_r[l] <= prod_r[l];
        end
        nr_r[l]   <= (num_r[l] + (64'sd1 <<< (F - 3))) >>> (F - 2);
        neg8_r[l] <= nr_r[l][63];
        m2_r[l]   <= CW'($unsigned(nr_r[l][63] ? dh - nr_r[l] : nr_r[l] + dh));
      end
    end
  end

  // Stage 9: quotients that would exceed QB bits saturate.
  assign dsh_ovf = CW'($unsigned(ctx_r[8].d)) << QB;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      sat_nxt[l] = (m2_r[l] >= dsh_ovf);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dd_r[0]          <= CW'($unsigned(ctx_r[8].d));
      side_r[0].fb     <= ctx_r[8].fb;
      side_r[0].neg    <= neg8_r;
      side_r[0].sat    <= sat_nxt;
      side_r[0].lin0   <= ctx_r[8].lin0;
      side_r[0].lin1   <= ctx_r[8].lin1;
      side_r[0].lin2   <= ctx_r[8].lin2;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_r[0][l] <= m2_r[l];
        q_r[0][l]   <= '0;
      end
      for (int g = 1; g <= QB; g++) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    rbuv_divstep #(
      .CW    (CW),
      .QW    (QB),
      .SHIFT (QB - 1 - g)
    ) u_divstep (
      .clk   (clk),
      .en    (pipe_en),
      .d_i   (dd_r[g]),
      .rem_i (rem_r[g]),
      .q_i   (q_r[g]),
      .d_r   (dd_r[g+1]),
      .rem_r (rem_r[g+1]),
      .q_r   (q_r[g+1])
    );
  end

  function automatic logic [15:0] clamp16(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    if (x > ONE_S) begin
      y = ONE_S;
    end else if (x < -ONE_S) begin
      y = -ONE_S;
    end else begin
      y = x;
    end
    return y[15:0];
  endfunction

  // Final stage: signed quotient plus linear and identity terms, then clamp; -I on fallback.
  logic signed [SW-1:0] quad [NUM_LANES];
  logic signed [SW-1:0] ln0, ln1, ln2;
  side_t                sd;

  always_comb begin
    sd  = side_r[QB];
    ln0 = SW'(sd.lin0);
    ln1 = SW'(sd.lin1);
    ln2 = SW'(sd.lin2);
    for (int l = 0; l < NUM_LANES; l++) begin
      quad[l] = sd.sat[l] ? ONE_S <<< (QB - F) : $signed(SW'(q_r[QB][l]));
      if (sd.neg[l]) begin
        quad[l] = -quad[l];
      end
    end
    if (sd.fb) begin
      res_nxt              = '0;
      res_nxt.m00          = NEG_ONE16;
      res_nxt.m11          = NEG_ONE16;
      res_nxt.m22          = NEG_ONE16;
      res_nxt.antiparallel = 1'b1;
    end else begin
      res_nxt.m00          = clamp16(ONE_S + quad[L_D0]);
      res_nxt.m11          = clamp16(ONE_S + quad[L_D1]);
      res_nxt.m22          = clamp16(ONE_S + quad[L_D2]);
      res_nxt.m01          = clamp16(quad[L_O01] - ln2);
      res_nxt.m10          = clamp16(quad[L_O01] + ln2);
      res_nxt.m02          = clamp16(quad[L_O02] + ln1);
      res_nxt.m20          = clamp16(quad[L_O02] - ln1);
      res_nxt.m12          = clamp16(quad[L_O12] - ln0);
      res_nxt.m21          = clamp16(quad[L_O12] + ln0);
      res_nxt.antiparallel = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rbuv_checker.sv
`default_nettype none
module rbuv_checker import rbuv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input rbuv_out_t out_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  // The fallback matrix has no off-diagonal entries.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.antiparallel |->
      out_data.m01 == 16'd0 && out_data.m02 == 16'd0 && out_data.m10 == 16'd0 &&
      out_data.m12 == 16'd0 && out_data.m20 == 16'd0 && out_data.m21 == 16'd0)
    else $error("fallback beat with nonzero off-diagonal entry");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind rotation_between_unit_vectors rbuv_checker u_rbuv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
